// ===== rtl/flc_pkg.sv =====
// shared constants and control types for the full linear convolution block
package flc_pkg;

  // default sizes
  localparam int unsigned MAX_TAPS     = 32;
  localparam int unsigned SAMPLE_WIDTH = 16;
  localparam int unsigned COEF_WIDTH   = 16;

  // fixed field widths
  localparam int unsigned CONV_WIDTH       = 37;
  localparam int unsigned TAP_COUNT_WIDTH  = 6;
  localparam int unsigned COEF_INDEX_WIDTH = 5;

  localparam logic [TAP_COUNT_WIDTH-1:0] TAP_COUNT_RESET = 6'd29;

  // action codes of a request
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic tap_we;      // write one coefficient from the input request
    logic line_we;     // push a sample into the delay line, start a new sum
    logic line_zero;   // pushed sample is zero (tail flush)
    logic rd_en;       // read one tap and one delay entry into the mac
    logic out_load;    // move the finished sum into the output register
    logic out_last;    // mark the loaded output as the final one of a block
    logic line_clear;  // empty the delay line
  } flc_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic mac_busy;    // products still in flight
    logic out_free;    // output register can take a new value
  } flc_stat_t;

endpackage

// ===== rtl/flc_in_if.sv =====
// input request channel: coefficient loads and signal samples
interface flc_in_if #(
  parameter int unsigned SAMPLE_WIDTH = flc_pkg::SAMPLE_WIDTH,
  parameter int unsigned COEF_WIDTH   = flc_pkg::COEF_WIDTH
);
  logic                                  valid;
  logic                                  ready;
  logic                                  action;
  logic [flc_pkg::COEF_INDEX_WIDTH-1:0]  coef_index;
  logic signed [COEF_WIDTH-1:0]          coef_value;
  logic signed [SAMPLE_WIDTH-1:0]        sample;
  logic                                  last_sample;

  modport source (
    output valid, action, coef_index, coef_value, sample, last_sample,
    input  ready
  );

  modport sink (
    input  valid, action, coef_index, coef_value, sample, last_sample,
    output ready
  );
endinterface

// ===== rtl/flc_out_if.sv =====
// output request channel: convolution values with block end mark
interface flc_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [flc_pkg::CONV_WIDTH-1:0] conv_value;
  logic                                  last_output;

  modport source (
    output valid, conv_value, last_output,
    input  ready
  );

  modport sink (
    input  valid, conv_value, last_output,
    output ready
  );
endinterface

// ===== rtl/full_linear_convolution_core.sv =====
// top level of the full linear convolution block
//
// Direct-form FIR used as a full linear convolution. Requests on in_i either
// load one coefficient (action 0, written at coef_index) or present one
// sample (action 1). Each sample gives one sum of products over the taps in
// use on out_o; a sample with last_sample set also flushes taps-1 tail
// outputs, the final one carrying last_output, and then empties the delay
// line. The user must write the tap count through cfg_we_i/cfg_data_i only
// while the block is idle; the block itself does not enforce this.
// Steps: a coefficient load is written into the tap store as it is
// accepted. A sample is pushed into the delay line as it is accepted (a
// tail output pushes a zero first), then each tap goes through the single
// multiply-accumulate unit (one tap store read and one delay line read per
// cycle) and the read, multiply and accumulate pipeline before the output
// register is loaded. A new request is taken as soon as the last output of
// the previous one sits in the output register, even while the receiver
// stalls; a stalled output holds back the next output load of any request.
// Reset clears the tap store and delay line (through valid bits, so no
// clearing pass), sets the tap count to 29 and empties the output register.
module full_linear_convolution_core #(
  parameter int unsigned MAX_TAPS     = flc_pkg::MAX_TAPS,
  parameter int unsigned SAMPLE_WIDTH = flc_pkg::SAMPLE_WIDTH,
  parameter int unsigned COEF_WIDTH   = flc_pkg::COEF_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [flc_pkg::TAP_COUNT_WIDTH-1:0] cfg_data_i,
  flc_in_if.sink                              in_i,
  flc_out_if.source                           out_o
);

  flc_pkg::flc_cmd_t  cmd;
  flc_pkg::flc_stat_t stat;

  logic                                   in_ready;
  logic                                   out_valid;
  logic signed [flc_pkg::CONV_WIDTH-1:0]  conv_value;
  logic                                   last_output;

  // sequencer
  flc_ctrl #(
    .MAX_TAPS (MAX_TAPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_last_i   (in_i.last_sample),
    .in_ready_o  (in_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // storage and arithmetic
  flc_dpath #(
    .MAX_TAPS     (MAX_TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .coef_index_i  (in_i.coef_index),
    .coef_value_i  (in_i.coef_value),
    .sample_i      (in_i.sample),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_valid),
    .conv_value_o  (conv_value),
    .last_output_o (last_output)
  );

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid;
  assign out_o.conv_value  = conv_value;
  assign out_o.last_output = last_output;

endmodule

// ===== rtl/flc_ram.sv =====
// generic single write port ram with registered read
module flc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/flc_ctrl.sv =====
// sequencer: request handshake, tap count register, per-output mac schedule
module flc_ctrl #(
  parameter int unsigned MAX_TAPS = flc_pkg::MAX_TAPS,
  localparam int unsigned CNT_W   = $clog2(MAX_TAPS + 1)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [flc_pkg::TAP_COUNT_WIDTH-1:0]  cfg_data_i,
  input  logic                                 in_valid_i,
  input  logic                                 in_action_i,
  input  logic                                 in_last_i,
  output logic                                 in_ready_o,
  input  flc_pkg::flc_stat_t                   stat_i,
  output flc_pkg::flc_cmd_t                    cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WRITE,
    S_MAC,
    S_DRAIN
  } state_e;

  state_e                                state_q;
  logic [flc_pkg::TAP_COUNT_WIDTH-1:0]   tap_count_q;
  logic [CNT_W-1:0]                      k_q;
  logic [CNT_W-1:0]                      tail_q;
  logic                                  last_blk_q;

  logic [CNT_W-1:0] taps_use;
  logic             accept;
  logic             out_go;
  logic             out_final;

  // taps in use: zero acts as one, large values saturate
  always_comb begin
    if (tap_count_q == '0) begin
      taps_use = CNT_W'(1);
    end else if (32'(tap_count_q) > MAX_TAPS) begin
      taps_use = CNT_W'(MAX_TAPS);
    end else begin
      taps_use = CNT_W'(tap_count_q);
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_go     = (state_q == S_DRAIN) && !stat_i.mac_busy && stat_i.out_free;
  assign out_final  = !last_blk_q || (tail_q == '0);

  // commands decoded from state
  always_comb begin
    cmd_o            = '0;
    cmd_o.tap_we     = accept && (in_action_i == flc_pkg::ACT_LOAD);
    cmd_o.line_we    = (accept && (in_action_i == flc_pkg::ACT_SAMPLE))
                       || (state_q == S_WRITE);
    cmd_o.line_zero  = (state_q == S_WRITE);
    cmd_o.rd_en      = (state_q == S_MAC);
    cmd_o.out_load   = out_go;
    cmd_o.out_last   = last_blk_q && (tail_q == '0);
    cmd_o.line_clear = out_go && last_blk_q && (tail_q == '0);
  end

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tap_count_q <= flc_pkg::TAP_COUNT_RESET;
      k_q         <= '0;
      tail_q      <= '0;
      last_blk_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tap_count_q <= cfg_data_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept && (in_action_i == flc_pkg::ACT_SAMPLE)) begin
            last_blk_q <= in_last_i;
            tail_q     <= taps_use - CNT_W'(1);
            k_q        <= '0;
            state_q    <= S_MAC;
          end
        end
        S_WRITE: begin
          k_q     <= '0;
          state_q <= S_MAC;
        end
        S_MAC: begin
          if (k_q == taps_use - CNT_W'(1)) begin
            state_q <= S_DRAIN;
          end else begin
            k_q <= k_q + CNT_W'(1);
          end
        end
        S_DRAIN: begin
          if (out_go) begin
            if (out_final) begin
              state_q <= S_IDLE;
            end else begin
              tail_q  <= tail_q - CNT_W'(1);
              state_q <= S_WRITE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/flc_dpath.sv =====
// datapath: tap store, circular delay line, serial mac and output register
module flc_dpath #(
  parameter int unsigned MAX_TAPS     = flc_pkg::MAX_TAPS,
  parameter int unsigned SAMPLE_WIDTH = flc_pkg::SAMPLE_WIDTH,
  parameter int unsigned COEF_WIDTH   = flc_pkg::COEF_WIDTH,
  localparam int unsigned AW          = $clog2(MAX_TAPS),
  localparam int unsigned PROD_W      = SAMPLE_WIDTH + COEF_WIDTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  flc_pkg::flc_cmd_t                     cmd_i,
  output flc_pkg::flc_stat_t                    stat_o,
  input  logic [flc_pkg::COEF_INDEX_WIDTH-1:0]  coef_index_i,
  input  logic signed [COEF_WIDTH-1:0]          coef_value_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        sample_i,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic signed [flc_pkg::CONV_WIDTH-1:0] conv_value_o,
  output logic                                  last_output_o
);

  logic [MAX_TAPS-1:0]              tap_vld_q;
  logic [MAX_TAPS-1:0]              line_vld_q;
  logic [AW-1:0]                    wp_q;
  logic [AW-1:0]                    wp_inc;
  logic [AW-1:0]                    rptr_q;
  logic [AW-1:0]                    tk_q;
  logic                             tv_q;
  logic                             lv_q;
  logic                             rd_vld_q;
  logic                             prod_vld_q;
  logic signed [PROD_W-1:0]         prod_q;
  logic signed [flc_pkg::CONV_WIDTH-1:0] acc_q;
  logic signed [flc_pkg::CONV_WIDTH-1:0] out_value_q;
  logic                             out_last_q;
  logic                             out_vld_q;

  logic                             idx_ok;
  logic                             tap_we;
  logic [AW-1:0]                    tap_waddr;
  logic [COEF_WIDTH-1:0]            tap_rdata;
  logic [SAMPLE_WIDTH-1:0]          line_wdata;
  logic [SAMPLE_WIDTH-1:0]          line_rdata;
  logic signed [COEF_WIDTH-1:0]     mul_a;
  logic signed [SAMPLE_WIDTH-1:0]   mul_b;

  // coefficient writes beyond the store are dropped
  assign idx_ok    = 32'(coef_index_i) < MAX_TAPS;
  assign tap_we    = cmd_i.tap_we && idx_ok;
  assign tap_waddr = AW'(coef_index_i);

  assign wp_inc     = (wp_q == AW'(MAX_TAPS - 1)) ? '0 : wp_q + AW'(1);
  assign line_wdata = cmd_i.line_zero ? '0 : sample_i;

  flc_ram #(
    .WIDTH (COEF_WIDTH),
    .DEPTH (MAX_TAPS)
  ) u_tap_ram (
    .clk_i   (clk_i),
    .we_i    (tap_we),
    .waddr_i (tap_waddr),
    .wdata_i (coef_value_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (tk_q),
    .rdata_o (tap_rdata)
  );

  flc_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (MAX_TAPS)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.line_we),
    .waddr_i (wp_inc),
    .wdata_i (line_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rptr_q),
    .rdata_o (line_rdata)
  );

  // entries never written read as zero
  assign mul_a = tv_q ? signed'(tap_rdata) : '0;
  assign mul_b = lv_q ? signed'(line_rdata) : '0;

  // valid bits, pointers and read pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_vld_q  <= '0;
      line_vld_q <= '0;
      wp_q       <= '0;
      rptr_q     <= '0;
      tk_q       <= '0;
      tv_q       <= 1'b0;
      lv_q       <= 1'b0;
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      if (tap_we) begin
        tap_vld_q[tap_waddr] <= 1'b1;
      end
      if (cmd_i.line_clear) begin
        line_vld_q <= '0;
      end else if (cmd_i.line_we) begin
        line_vld_q[wp_inc] <= 1'b1;
      end
      if (cmd_i.line_we) begin
        wp_q   <= wp_inc;
        rptr_q <= wp_inc;
        tk_q   <= '0;
      end else if (cmd_i.rd_en) begin
        rptr_q <= (rptr_q == '0) ? AW'(MAX_TAPS - 1) : rptr_q - AW'(1);
        tk_q   <= tk_q + AW'(1);
      end
      if (cmd_i.rd_en) begin
        tv_q <= tap_vld_q[tk_q];
        lv_q <= line_vld_q[rptr_q];
      end
      rd_vld_q   <= cmd_i.rd_en;
      prod_vld_q <= rd_vld_q;
    end
  end

  // multiply stage
  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prod_q <= mul_a * mul_b;
    end
  end

  // accumulate stage, wraps at the output width
  always_ff @(posedge clk_i) begin
    if (cmd_i.line_we) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + flc_pkg::CONV_WIDTH'(prod_q);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_value_q <= acc_q;
      out_last_q  <= cmd_i.out_last;
    end
  end

  assign stat_o.mac_busy = rd_vld_q || prod_vld_q;
  assign stat_o.out_free = !out_vld_q || out_ready_i;

  assign out_valid_o   = out_vld_q;
  assign conv_value_o  = out_value_q;
  assign last_output_o = out_last_q;

endmodule

// ===== rtl/flc_checker.sv =====
// port-level checks for the full linear convolution block, bound to the top
module flc_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_ready_i,
  input logic                                  in_action_i,
  input logic                                  out_valid_i,
  input logic                                  out_ready_i,
  input logic signed [flc_pkg::CONV_WIDTH-1:0] out_value_i,
  input logic                                  out_last_i
);

  // a stalled output stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("output dropped while stalled");

  // a stalled output keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> ($stable(out_value_i) && $stable(out_last_i)))
    else $error("output payload changed while stalled");

  // a sample request keeps the input closed while its sum runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_action_i == flc_pkg::ACT_SAMPLE)) |=> !in_ready_i)
    else $error("input reopened during a sum");

  // a sample request is followed by no new output before the mac pipeline could give one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_action_i == flc_pkg::ACT_SAMPLE))
      |=> !$rose(out_valid_i) ##1 !$rose(out_valid_i) ##1 !$rose(out_valid_i))
    else $error("output faster than the mac pipeline");

endmodule

bind full_linear_convolution_core flc_checker u_flc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_action_i (in_i.action),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.conv_value),
  .out_last_i  (out_o.last_output)
);

// ===== tb/testbench.sv =====
// self-checking testbench for the full linear convolution core
module testbench;

  localparam int unsigned MAX_TAPS         = flc_pkg::MAX_TAPS;
  localparam int unsigned SAMPLE_WIDTH     = flc_pkg::SAMPLE_WIDTH;
  localparam int unsigned COEF_WIDTH       = flc_pkg::COEF_WIDTH;
  localparam int unsigned CONV_WIDTH       = flc_pkg::CONV_WIDTH;
  localparam int unsigned TAP_COUNT_WIDTH  = flc_pkg::TAP_COUNT_WIDTH;
  localparam int unsigned COEF_INDEX_WIDTH = flc_pkg::COEF_INDEX_WIDTH;

  localparam int DRAIN       = MAX_TAPS + 8;  // one output slot plus margin
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG    = 5000;
  localparam int NUM_PHASES  = 9;

  typedef enum {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_e;

  // one stimulus row: a tap count write or a request, with optional typed result
  typedef struct packed {
    logic                          is_cfg;
    logic [TAP_COUNT_WIDTH-1:0]    cfg;
    logic                          action;
    logic [COEF_INDEX_WIDTH-1:0]   idx;
    logic signed [COEF_WIDTH-1:0]  coef;
    logic signed [SAMPLE_WIDTH-1:0] smp;
    logic                          last;
    logic                          known;
    logic signed [CONV_WIDTH-1:0]  exp_value;
    logic                          exp_last;
  } req_t;

  typedef struct packed {
    logic signed [CONV_WIDTH-1:0] value;
    logic                         last;
  } conv_out_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [TAP_COUNT_WIDTH-1:0] cfg_data;

  flc_in_if  req_if ();
  flc_out_if conv_if ();

  full_linear_convolution_core dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data),
    .in_i      (req_if),
    .out_o     (conv_if)
  );

  // filter mirror: taps, past samples, tap count
  logic signed [COEF_WIDTH-1:0]   tap_mirror  [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] line_mirror [MAX_TAPS-1];
  logic [TAP_COUNT_WIDTH-1:0]     tap_count_mirror;

  conv_out_t conv_due_q [$];
  req_t      offered_q [$];
  req_t      directed_rows [$];
  conv_out_t head;

  int unsigned burst_left;
  bit          gappy;
  rx_mode_e    rx_mode;
  bit          hold_req;
  bit          hold_taken;
  int unsigned rx_tick;
  int          err_count;
  int          quiet_cycles;

  int unsigned phase_cfg   [NUM_PHASES] = '{3, 32, 1, 8, 0, 17, 63, 5, 2};
  int unsigned phase_items [NUM_PHASES] = '{80, 30, 40, 60, 25, 40, 20, 60, 55};

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // one direct-form step: sum for newest sample x, then shift x into the line
  function automatic logic signed [CONV_WIDTH-1:0] fir_advance(
    input logic signed [SAMPLE_WIDTH-1:0] x, input int unsigned taps);
    longint acc;
    acc = longint'(tap_mirror[0]) * longint'(x);
    for (int k = 1; k < taps; k++)
      acc += longint'(tap_mirror[k]) * longint'(line_mirror[k-1]);
    for (int k = MAX_TAPS - 2; k > 0; k--)
      line_mirror[k] = line_mirror[k-1];
    line_mirror[0] = x;
    return acc[CONV_WIDTH-1:0];
  endfunction

  // outputs caused by one accepted request
  function automatic void forecast_outputs(
    input logic action, input logic [COEF_INDEX_WIDTH-1:0] idx,
    input logic signed [COEF_WIDTH-1:0] coef, input logic signed [SAMPLE_WIDTH-1:0] x,
    input logic last, input req_t typed);
    conv_out_t   r;
    int unsigned taps;
    if (action == flc_pkg::ACT_LOAD) begin
      tap_mirror[idx] = coef;
      return;
    end
    // zero means one tap, anything past the store saturates
    taps = (tap_count_mirror == 0) ? 1 :
           (tap_count_mirror > MAX_TAPS) ? MAX_TAPS : tap_count_mirror;
    r.value = fir_advance(x, taps);
    r.last  = last && (taps == 1);
    if (typed.known) begin
      r.value = typed.exp_value;
      r.last  = typed.exp_last;
    end
    conv_due_q.push_back(r);
    // tail flush with zeros, then an empty line
    if (last) begin
      for (int t = 1; t < taps; t++) begin
        r.value = fir_advance('0, taps);
        r.last  = (t == taps - 1);
        conv_due_q.push_back(r);
      end
      foreach (line_mirror[k]) line_mirror[k] = '0;
    end
  endfunction

  // row builders for the directed table
  function automatic req_t row_load(input int idx, input int val);
    req_t r;
    r        = '0;
    r.action = flc_pkg::ACT_LOAD;
    r.idx    = COEF_INDEX_WIDTH'(idx);
    r.coef   = COEF_WIDTH'(val);
    r.smp    = 16'sh8000;  // ignored by a load
    r.last   = 1'b1;       // ignored by a load
    return r;
  endfunction

  function automatic req_t row_sample(input int x, input bit last);
    req_t r;
    r        = '0;
    r.action = flc_pkg::ACT_SAMPLE;
    r.smp    = SAMPLE_WIDTH'(x);
    r.last   = last;
    return r;
  endfunction

  function automatic req_t row_known(input int x, input bit last, input longint v, input bit l);
    req_t r;
    r           = row_sample(x, last);
    r.known     = 1'b1;
    r.exp_value = CONV_WIDTH'(v);
    r.exp_last  = l;
    return r;
  endfunction

  function automatic req_t row_cfg(input int v);
    req_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.cfg    = TAP_COUNT_WIDTH'(v);
    return r;
  endfunction

  function automatic logic signed [15:0] rand_q15();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // offer one request, with bursts and gaps, until it is taken
  task automatic offer(input req_t r);
    if (gappy && burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    offered_q.push_back(r);
    req_if.valid       <= 1'b1;
    req_if.action      <= r.action;
    req_if.coef_index  <= r.idx;
    req_if.coef_value  <= r.coef;
    req_if.sample      <= r.smp;
    req_if.last_sample <= r.last;
    do @(posedge clk); while (!(req_if.valid && req_if.ready));
  endtask

  // stop offering and wait until every output is back and the core is quiet
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (offered_q.size() != 0 || conv_due_q.size() != 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_tap_count(input logic [TAP_COUNT_WIDTH-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    tap_count_mirror = v;
  endtask

  // receiver: stall pattern per mode, one long hold-off on request
  initial begin
    conv_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      rx_tick++;
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        conv_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      case (rx_mode)
        RX_ALWAYS:   conv_if.ready <= 1'b1;
        RX_RANDOM:   conv_if.ready <= 1'($urandom_range(0, 1));
        RX_PERIODIC: conv_if.ready <= (rx_tick % 7) >= 3;
        default:     conv_if.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // monitor: predict on accepted requests, check accepted outputs, watchdog
  always @(posedge clk) begin
    if (req_if.valid && req_if.ready)
      forecast_outputs(req_if.action, req_if.coef_index, req_if.coef_value,
                       req_if.sample, req_if.last_sample, offered_q.pop_front());
    if (conv_if.valid && conv_if.ready) begin
      if (conv_due_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected output: conv_value %0d last_output %0b",
                   conv_if.conv_value, conv_if.last_output);
      end else begin
        head = conv_due_q.pop_front();
        if (head.value !== conv_if.conv_value || head.last !== conv_if.last_output) begin
          err_count++;
          if (err_count <= 10)
            $display("output mismatch: expected %0d/%0b, got %0d/%0b",
                     head.value, head.last, conv_if.conv_value, conv_if.last_output);
        end
      end
    end
    if ((req_if.valid && req_if.ready) || (conv_if.valid && conv_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // main sequence
  initial begin
    req_t        r;
    int unsigned block_left;
    int unsigned preload;

    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_data           = '0;
    req_if.valid       = 1'b0;
    req_if.action      = flc_pkg::ACT_LOAD;
    req_if.coef_index  = '0;
    req_if.coef_value  = '0;
    req_if.sample      = '0;
    req_if.last_sample = 1'b0;
    foreach (tap_mirror[k]) tap_mirror[k] = '0;
    foreach (line_mirror[k]) line_mirror[k] = '0;
    tap_count_mirror = flc_pkg::TAP_COUNT_RESET;
    rx_mode    = RX_RANDOM;
    gappy      = 1'b1;
    burst_left = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset state, field extremes, tap count corner cases
    directed_rows = '{
      row_known(32767, 1'b0, 0, 1'b0),            // empty taps after reset
      row_known(-32768, 1'b1, 0, 1'b0),           // flush at reset tap count
      row_load(0, 32767),
      row_load(31, -32768),
      row_load(1, -1),
      row_load(28, 21845),
      row_known(32767, 1'b0, 1073676289, 1'b0),   // line was cleared
      row_sample(-32768, 1'b0),
      row_sample(1, 1'b1),
      row_cfg(0),                                 // zero count acts as one tap
      row_known(100, 1'b1, 3276700, 1'b1),        // single tap, own output is final
      row_cfg(63),                                // saturates to full store
      row_load(31, 32767),
      row_sample(-32768, 1'b0),
      row_sample(32767, 1'b1),
      row_cfg(1),
      row_known(-32768, 1'b1, -1073709056, 1'b1),
      row_cfg(32),
      row_load(5, -32768),
      row_sample(-32768, 1'b1),
      row_sample(-32768, 1'b1)
    };
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        wait_idle();
        write_tap_count(directed_rows[i].cfg);
      end else begin
        offer(directed_rows[i]);
      end
    end

    // random phases: coefficient preload, then blocks of samples
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_tap_count(TAP_COUNT_WIDTH'(phase_cfg[p]));
      rx_mode    = rx_mode_e'(p % 4);
      gappy      = (p % 2 == 0);
      burst_left = 0;
      if (p == 7) hold_req = 1'b1;
      preload = (phase_cfg[p] == 0) ? 1 : (phase_cfg[p] > MAX_TAPS) ? MAX_TAPS : phase_cfg[p];
      if (preload > phase_items[p] / 2) preload = phase_items[p] / 2;
      block_left = $urandom_range(1, 12);
      for (int i = 0; i < phase_items[p]; i++) begin
        r      = '0;
        r.idx  = COEF_INDEX_WIDTH'($urandom_range(0, 31));
        r.coef = rand_q15();
        r.smp  = rand_q15();
        r.last = 1'($urandom_range(0, 1));
        if (i < preload) begin
          r.action = flc_pkg::ACT_LOAD;
          r.idx    = COEF_INDEX_WIDTH'(i);
        end else if ($urandom_range(0, 5) == 0) begin
          r.action = flc_pkg::ACT_LOAD;  // coefficient change in mid block
        end else begin
          r.action = flc_pkg::ACT_SAMPLE;
          r.last   = (block_left == 1);
          if (block_left == 1) block_left = $urandom_range(1, 12);
          else block_left--;
        end
        offer(r);
      end
    end

    wait_idle();
    repeat (2 * DRAIN) @(posedge clk);
    if (err_count == 0 && conv_due_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
